FILE: rtl/integer_square_root_macros.svh
// ---------------------------------------------------------------------------
// integer_square_root_macros.svh
// Assertion macros shared by the square root block.
// ---------------------------------------------------------------------------
`ifndef INTEGER_SQUARE_ROOT_MACROS_SVH
`define INTEGER_SQUARE_ROOT_MACROS_SVH

// Same-cycle implication, clocked on clk, held off during reset.
`define ISQRT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, held off during reset.
`define ISQRT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/isqrt_pkg.sv
// ---------------------------------------------------------------------------
// isqrt_pkg
// Types and constants shared by the square root controller and datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package isqrt_pkg;

    localparam int OPERAND_W  = 32;
    localparam int ROOT_W     = 24;
    localparam int STEPS      = 16;
    localparam int STEP_CNT_W = 4;

    // Operation select
    localparam logic OP_UNSIGNED = 1'b0;
    localparam logic OP_FIXED    = 1'b1;

    // Weight of the top radicand bit pair.
    localparam logic [OPERAND_W-1:0] TOP_PAIR = 32'h4000_0000;

    typedef struct packed {
        logic load;     // take a new request into the datapath
        logic step;     // one two-bit compare-subtract iteration
        logic publish;  // move the finished root into the output register
    } isqrt_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/isqrt_datapath.sv
// ---------------------------------------------------------------------------
// isqrt_datapath
// Restoring square root datapath: remainder, root accumulator, probe bit,
// one shared compare-subtract unit and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module isqrt_datapath
    import isqrt_pkg::*;
#(
    parameter int SHIFT = 8
)
(
    input  wire logic                 clk,
    input  wire isqrt_cmd_t           cmd,
    input  wire logic                 operation,
    input  wire logic [OPERAND_W-1:0] operand,
    output logic      [ROOT_W-1:0]    root
);

    logic [OPERAND_W-1:0] rem_reg;
    logic [OPERAND_W-1:0] acc_reg;
    logic [OPERAND_W-1:0] probe_reg;
    logic                 op_reg;
    logic                 neg_reg;
    logic [ROOT_W-1:0]    root_reg;

    logic [OPERAND_W-1:0] trial;
    logic                 fits;
    logic [ROOT_W-1:0]    root_next;

    // acc never overlaps the probe bit, so the add is an OR
    assign trial = acc_reg | probe_reg;
    assign fits  = (rem_reg >= trial);

    always_comb
    begin
        if (op_reg == OP_UNSIGNED)
        begin
            root_next = {{(ROOT_W-16){1'b0}}, acc_reg[15:0]};
        end
        else if (neg_reg)
        begin
            root_next = '0;
        end
        else
        begin
            root_next = {{(ROOT_W-16){1'b0}}, acc_reg[15:0]} << SHIFT;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rem_reg   <= operand;
            acc_reg   <= '0;
            probe_reg <= TOP_PAIR;
            op_reg    <= operation;
            neg_reg   <= operand[OPERAND_W-1];
        end
        else if (cmd.step)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - trial;
                acc_reg <= (acc_reg >> 1) + probe_reg;
            end
            else
            begin
                acc_reg <= acc_reg >> 1;
            end
            probe_reg <= probe_reg >> 2;
        end
        if (cmd.publish)
        begin
            root_reg <= root_next;
        end
    end

    assign root = root_reg;

endmodule

`default_nettype wire

FILE: rtl/isqrt_ctrl.sv
// ---------------------------------------------------------------------------
// isqrt_ctrl
// Sequencer for the square root: request acceptance, step count and
// output valid handling.
// ---------------------------------------------------------------------------
`default_nettype none

module isqrt_ctrl
    import isqrt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  wire logic out_stall,
    output isqrt_cmd_t cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    logic [STEP_CNT_W-1:0] cnt_reg;
    logic [STEP_CNT_W-1:0] cnt_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;

    logic out_free;
    logic accept;

    assign out_free = !out_valid_reg || !out_stall;
    // a new request may enter while the finished root moves out
    assign in_stall = !((state_reg == S_IDLE) || ((state_reg == S_DONE) && out_free));
    assign accept   = in_valid && !in_stall;

    assign cmd.load    = accept;
    assign cmd.step    = (state_reg == S_RUN);
    assign cmd.publish = (state_reg == S_DONE) && out_free;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_RUN;
                    cnt_next   = '0;
                end
            end
            S_RUN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_CNT_W'(STEPS - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = accept ? S_RUN : S_IDLE;
                    cnt_next   = '0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.publish)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: rtl/integer_square_root.sv
// The datapath runs 16 steps after acceptance; publishing the root sets out_valid.
// New requests wait until the root is published; the single compare-subtract
// unit retires two radicand bits per cycle.
// A finished root waits in the output register while the next request computes.
// Reset (rst_n, async, active low) clears the controller and output valid only.
// ---------------------------------------------------------------------------
// integer_square_root
// Floor square root of a 32-bit operand, unsigned integer or signed fixed point.
// ---------------------------------------------------------------------------
`default_nettype none
`include "integer_square_root_macros.svh"

module integer_square_root
    import isqrt_pkg::*;
#(
    parameter int FRACTION_BITS = 16
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 operation,
    input  wire logic [OPERAND_W-1:0] operand,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic      [ROOT_W-1:0]    root
);

    localparam int SHIFT = FRACTION_BITS / 2;

    isqrt_cmd_t cmd;

    isqrt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    isqrt_datapath #(
        .SHIFT (SHIFT)
    ) u_datapath (
        .clk       (clk),
        .cmd       (cmd),
        .operation (operation),
        .operand   (operand),
        .root      (root)
    );

    `ISQRT_ASSERT_IMPL(a_load_not_step, cmd.load, !cmd.step, "load during an iteration")
    `ISQRT_ASSERT_NEXT(a_load_then_step, cmd.load, cmd.step, "no iteration after load")
    `ISQRT_ASSERT_IMPL(a_no_overwrite, cmd.publish, !out_valid || !out_stall,
        "output register overwritten while stalled")
    `ISQRT_ASSERT_NEXT(a_publish_valid, cmd.publish, out_valid, "published root not valid")

endmodule

`default_nettype wire
